// ----- hw/rtl/espp_pkg.sv -----
package espp_pkg;

    // Input word kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_APPEND = 3'd1;
    localparam logic [2:0] KIND_PLAY   = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Easing curves
    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_IN     = 2'd1;
    localparam logic [1:0] EASE_OUT    = 2'd2;
    localparam logic [1:0] EASE_IN_OUT = 2'd3;

    // Configuration register indexes
    localparam logic REG_LOOP_ENABLE = 1'b0;
    localparam logic REG_FRAME_STEP  = 1'b1;

    localparam logic [15:0] FRAME_STEP_RESET = 16'd1092;
    localparam logic [16:0] ONE_Q16          = 17'd65536;
    localparam logic [16:0] HALF_Q16         = 17'd32768;
    localparam logic [17:0] TWO_Q16          = 18'd131072;
    localparam logic [4:0]  DIV_STEPS        = 5'd24;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_APPEND,
        OP_PLAY,
        OP_PAUSE,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_EASE,
        S_LERP,
        S_POS,
        S_DIV,
        S_APPEND,
        S_FINISH
    } t_bstate;

endpackage

// ----- hw/rtl/espp_front.sv -----
module espp_front import espp_pkg::*; #(
    parameter int COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_kind,
    input  logic [6*COORD_BITS+34:0]    i_payload,
    output logic                        o_valid,
    input  logic                        i_take,
    output t_op                         o_op,
    output logic [6*COORD_BITS+34:0]    o_payload
);
    localparam int PW = 6*COORD_BITS+35;

    t_op             w_op;
    t_op             r_op_q [2];
    logic [PW-1:0]   r_pay_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;

    // classify the word kind
    always_comb begin
        unique case (i_kind)
            KIND_TICK:   w_op = OP_TICK;
            KIND_APPEND: w_op = OP_APPEND;
            KIND_PLAY:   w_op = OP_PLAY;
            KIND_PAUSE:  w_op = OP_PAUSE;
            KIND_CLEAR:  w_op = OP_CLEAR;
            default:     w_op = OP_NOP;
        endcase
    end

    assign full      = (r_cnt == 2'd2);
    assign w_push    = push && !full;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_op      = r_op_q[r_rp];
    assign o_payload = r_pay_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op_q[r_wp]  <= w_op;
            r_pay_q[r_wp] <= i_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (i_take) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_take};
        end
    end

endmodule

// ----- hw/rtl/espp_back.sv -----
module espp_back import espp_pkg::*; #(
    parameter int MAX_SEGMENTS,
    parameter int COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_take,
    input  t_op                         i_op,
    input  logic [6*COORD_BITS+34:0]    i_payload,
    input  logic                        i_loop_en,
    input  logic [15:0]                 i_frame_step,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_status,
    output logic [16:0]                 o_eased_time,
    output logic [COORD_BITS-1:0]       o_pos_x,
    output logic [COORD_BITS-1:0]       o_pos_y,
    output logic [COORD_BITS-1:0]       o_pos_z,
    output logic [3:0]                  o_segment_index,
    output logic                        o_segment_done,
    output logic                        o_running
);
    localparam int C   = COORD_BITS;
    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int PW  = 6*C + 35;
    localparam int RW  = 6*C + 19;
    localparam int OW  = 3*C + 25;
    localparam int PRW = C + 19;

    t_bstate            r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_cur;
    logic               r_playing;
    logic               r_clr_act;
    logic [CW-1:0]      r_clr_lo, r_clr_hi;
    t_op                r_op;
    logic [PW-1:0]      r_payload;
    logic [1:0]         r_fin_status;

    logic [RW-1:0]      seg_mem [MAX_SEGMENTS];
    logic [16:0]        tim_mem [MAX_SEGMENTS];
    logic [RW-1:0]      r_seg_rd;
    logic [16:0]        r_tim_rd;

    logic [16:0]        r_t, r_eased;
    logic signed [PRW-1:0] r_prod [3];
    logic [15:0]        r_rem;
    logic [23:0]        r_q;
    logic [4:0]         r_div_cnt;

    logic [OW-1:0]      r_oq [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_ocnt;

    logic [CW-1:0]      w_cur_ext;
    logic               w_tickable, w_full, w_done, w_has_next, w_push, w_pop;
    logic [16:0]        w_tim_cur, w_t, w_eased, w_step, w_itime;
    logic [17:0]        w_sum;
    logic [16:0]        w_trial, w_tdiff;
    logic [15:0]        w_speed;
    logic               w_ge;
    logic               w_seg_we, w_tim_we;
    logic [IW-1:0]      w_tim_addr, w_app_addr;
    logic [16:0]        w_tim_data;
    logic [RW-1:0]      w_seg_data;
    logic [OW-1:0]      w_res;
    logic [IW+3:0]      w_seg_ext;
    logic [IW-1:0]      w_seg_val;
    logic               w_run;
    logic [1:0]         w_ease;
    logic [16:0]        w_ma, w_v;
    logic [17:0]        w_mb;
    logic [34:0]        w_mprod;
    logic [C-1:0]       w_sp [3];
    logic [C-1:0]       w_ep [3];
    logic signed [C:0]  w_diff [3];
    logic [C-1:0]       w_pos [3];
    logic signed [C+2:0] w_q3 [3];
    logic signed [C+2:0] w_psum [3];

    assign w_cur_ext  = CW'(r_cur);
    assign w_tickable = r_playing && (r_count != '0) && (w_cur_ext < r_count);
    assign w_full     = (r_count >= CW'(MAX_SEGMENTS));
    assign w_tim_cur  = (r_clr_act && (w_cur_ext >= r_clr_lo) && (w_cur_ext < r_clr_hi))
                        ? 17'd0 : r_tim_rd;
    assign w_sum      = {1'b0, w_tim_cur} + {1'b0, r_seg_rd[16:0]};
    assign w_t        = (w_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : w_sum[16:0];
    assign w_done     = (r_t == ONE_Q16);
    assign w_has_next = ((w_cur_ext + 1'b1) < r_count);
    assign w_app_addr = r_count[IW-1:0];
    assign w_speed    = r_payload[32:17];
    assign w_itime    = (r_payload[16:0] > ONE_Q16) ? ONE_Q16 : r_payload[16:0];
    assign w_step     = (r_q > 24'd65536) ? ONE_Q16 : r_q[16:0];

    // restoring divider, one quotient bit a cycle
    assign w_trial = {r_rem, r_q[23]};
    assign w_ge    = (w_trial >= {1'b0, w_speed});
    assign w_tdiff = w_trial - {1'b0, w_speed};

    // easing multiply
    assign w_ease = r_seg_rd[18:17];
    assign w_v    = {r_t[15:0], 1'b0} - ONE_Q16;
    always_comb begin
        w_ma = r_t;
        w_mb = {1'b0, r_t};
        case (w_ease)
            EASE_OUT: w_mb = TWO_Q16 - {1'b0, r_t};
            EASE_IN_OUT: begin
                if (r_t > HALF_Q16) begin
                    w_ma = w_v;
                    w_mb = TWO_Q16 - {1'b0, w_v};
                end
            end
            default: ;
        endcase
    end
    assign w_mprod = w_ma * w_mb;
    always_comb begin
        case (w_ease)
            EASE_IN, EASE_OUT: w_eased = w_mprod[32:16];
            EASE_IN_OUT: begin
                if (r_t > HALF_Q16) w_eased = w_mprod[33:17] + HALF_Q16;
                else                w_eased = w_mprod[31:15];
            end
            default: w_eased = r_t;
        endcase
    end

    // three lanes of interpolation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sp[k]   = r_seg_rd[RW-1-k*C -: C];
            w_ep[k]   = r_seg_rd[RW-1-(3+k)*C -: C];
            w_diff[k] = $signed({w_ep[k][C-1], w_ep[k]}) - $signed({w_sp[k][C-1], w_sp[k]});
            w_q3[k]   = r_prod[k][PRW-1:16];
            w_psum[k] = $signed({{3{w_sp[k][C-1]}}, w_sp[k]}) + w_q3[k];
            if (w_psum[k][C+2:C-1] == 4'b0000 || w_psum[k][C+2:C-1] == 4'b1111)
                w_pos[k] = w_psum[k][C-1:0];
            else if (w_psum[k][C+2])
                w_pos[k] = {1'b1, {(C-1){1'b0}}};
            else
                w_pos[k] = {1'b0, {(C-1){1'b1}}};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && r_ocnt != 2'd2) begin
                    case (i_op)
                        OP_TICK:   n_state = w_tickable ? S_STEP : S_FINISH;
                        OP_APPEND: n_state = w_full ? S_FINISH : S_DIV;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_STEP:   n_state = S_EASE;
            S_EASE:   n_state = S_LERP;
            S_LERP:   n_state = S_POS;
            S_POS:    n_state = S_IDLE;
            S_DIV:    n_state = (r_div_cnt == 5'd1) ? S_APPEND : S_DIV;
            S_APPEND: n_state = S_IDLE;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_take     = 1'b0;
        w_push     = 1'b0;
        w_tim_we   = 1'b0;
        w_seg_we   = 1'b0;
        w_tim_addr = r_cur;
        w_tim_data = w_t;
        w_seg_data = {r_payload[PW-1:33], w_step};
        w_seg_val  = r_cur;
        w_run      = r_playing;
        w_res      = '0;
        unique case (r_state)
            S_IDLE: o_take = i_valid && (r_ocnt != 2'd2);
            S_STEP: w_tim_we = 1'b1;
            S_POS: begin
                w_push = 1'b1;
                w_run  = (w_done && !w_has_next && !i_loop_en) ? 1'b0 : r_playing;
            end
            S_APPEND: begin
                w_push     = 1'b1;
                w_tim_we   = 1'b1;
                w_seg_we   = 1'b1;
                w_tim_addr = w_app_addr;
                w_tim_data = w_itime;
            end
            S_FINISH: begin
                w_push = 1'b1;
                case (r_op)
                    OP_PLAY:  w_run = 1'b1;
                    OP_PAUSE: w_run = 1'b0;
                    OP_CLEAR: begin
                        w_run     = 1'b0;
                        w_seg_val = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        w_seg_ext = {4'b0000, w_seg_val};
        if (r_state == S_POS)
            w_res = {STATUS_DONE, r_eased, w_pos[0], w_pos[1], w_pos[2],
                     w_seg_ext[3:0], w_done, w_run};
        else if (r_state == S_FINISH)
            w_res = {r_fin_status, 17'd0, {(3*C){1'b0}}, w_seg_ext[3:0], 1'b0, w_run};
        else
            w_res = {STATUS_DONE, 17'd0, {(3*C){1'b0}}, w_seg_ext[3:0], 1'b0, w_run};
    end

    // segment table and timers
    always_ff @(posedge i_clk) begin
        if (w_seg_we) seg_mem[w_app_addr] <= w_seg_data;
        if (w_tim_we) tim_mem[w_tim_addr] <= w_tim_data;
        r_seg_rd <= seg_mem[r_cur];
        r_tim_rd <= tim_mem[r_cur];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_op       <= i_op;
            r_payload  <= i_payload;
            r_rem      <= '0;
            r_q        <= {i_frame_step, 8'd0};
            r_div_cnt  <= DIV_STEPS;
            if (i_op == OP_TICK)        r_fin_status <= STATUS_IGNORED;
            else if (i_op == OP_APPEND) r_fin_status <= STATUS_FULL;
            else                        r_fin_status <= STATUS_DONE;
        end
        if (r_state == S_STEP) r_t <= w_t;
        if (r_state == S_EASE) r_eased <= w_eased;
        if (r_state == S_LERP) begin
            for (int k = 0; k < 3; k++)
                r_prod[k] <= w_diff[k] * $signed({1'b0, r_eased});
        end
        if (r_state == S_DIV) begin
            r_rem     <= w_ge ? w_tdiff[15:0] : w_trial[15:0];
            r_q       <= {r_q[22:0], w_ge};
            r_div_cnt <= r_div_cnt - 5'd1;
        end
        if (w_push) r_oq[r_wp] <= w_res;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_playing <= 1'b0;
            r_clr_act <= 1'b0;
            r_clr_lo  <= '0;
            r_clr_hi  <= '0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_ocnt    <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_STEP: begin
                    if (r_clr_act && w_cur_ext == r_clr_lo) r_clr_lo <= r_clr_lo + 1'b1;
                end
                S_POS: begin
                    if (w_done) begin
                        if (w_has_next) begin
                            r_cur <= r_cur + 1'b1;
                        end else if (i_loop_en) begin
                            r_cur     <= '0;
                            r_clr_act <= 1'b1;
                            r_clr_lo  <= '0;
                            r_clr_hi  <= r_count;
                        end else begin
                            r_playing <= 1'b0;
                        end
                    end
                end
                S_APPEND: r_count <= r_count + 1'b1;
                S_FINISH: begin
                    case (r_op)
                        OP_PLAY:  r_playing <= 1'b1;
                        OP_PAUSE: r_playing <= 1'b0;
                        OP_CLEAR: begin
                            r_playing <= 1'b0;
                            r_count   <= '0;
                            r_cur     <= '0;
                            r_clr_act <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_ocnt <= r_ocnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign empty = (r_ocnt == 2'd0);
    assign w_pop = pop && !empty;
    assign {o_status, o_eased_time, o_pos_x, o_pos_y, o_pos_z,
            o_segment_index, o_segment_done, o_running} = r_oq[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_ocnt != 2'd2))
        else $error("result queue overflow");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (w_cur_ext < r_count))
        else $error("tick on a segment beyond the table");

    a_eased_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LERP) |-> (r_eased <= ONE_Q16))
        else $error("eased time above one");

    a_stop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS && w_done && !w_has_next && !i_loop_en) |=> !r_playing)
        else $error("playback did not stop after the last segment");

endmodule

// ----- hw/rtl/eased_segment_path_player.sv -----
// Channel   Handshake               Payload
// input     push / full             i_kind, i_start_*, i_end_*, i_ease_type, i_speed,
//                                   i_initial_time
// result    empty / pop             o_status, o_eased_time, o_pos_*, o_segment_index,
//                                   o_segment_done, o_running
// config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// Steps: a tick that plays goes through dispatch, timer step, ease multiply,
// interpolation multiply, saturate and write back; an append runs the 24-step
// quotient loop that derives the per-tick step; other words dispatch and finish.
// Reset (i_rst_n low, synchronous) empties both queues, the table and playback.
// A two-word input queue and a two-word result queue let either side stall alone.
module eased_segment_path_player import espp_pkg::*; #(
    parameter int MAX_SEGMENTS = 16,
    parameter int COORD_BITS   = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [2:0]              i_kind,
    input  logic [COORD_BITS-1:0]   i_start_x,
    input  logic [COORD_BITS-1:0]   i_start_y,
    input  logic [COORD_BITS-1:0]   i_start_z,
    input  logic [COORD_BITS-1:0]   i_end_x,
    input  logic [COORD_BITS-1:0]   i_end_y,
    input  logic [COORD_BITS-1:0]   i_end_z,
    input  logic [1:0]              i_ease_type,
    input  logic [15:0]             i_speed,
    input  logic [16:0]             i_initial_time,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_status,
    output logic [16:0]             o_eased_time,
    output logic [COORD_BITS-1:0]   o_pos_x,
    output logic [COORD_BITS-1:0]   o_pos_y,
    output logic [COORD_BITS-1:0]   o_pos_z,
    output logic [3:0]              o_segment_index,
    output logic                    o_segment_done,
    output logic                    o_running,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int PW = 6*COORD_BITS + 35;

    logic               r_loop_en;
    logic [15:0]        r_frame_step;
    logic [PW-1:0]      w_payload, w_q_payload;
    logic               w_valid, w_take;
    t_op                w_op;

    // configuration registers: index is address bit 2
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_en    <= 1'b0;
            r_frame_step <= FRAME_STEP_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LOOP_ENABLE) r_loop_en    <= pwdata[0];
            else                             r_frame_step <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == REG_FRAME_STEP) ? {16'd0, r_frame_step} : {31'd0, r_loop_en};

    // pack the append fields into one word for the input queue
    assign w_payload = {i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z,
                        i_ease_type, i_speed, i_initial_time};

    espp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_kind    (i_kind),
        .i_payload (w_payload),
        .o_valid   (w_valid),
        .i_take    (w_take),
        .o_op      (w_op),
        .o_payload (w_q_payload)
    );

    espp_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid),
        .o_take          (w_take),
        .i_op            (w_op),
        .i_payload       (w_q_payload),
        .i_loop_en       (r_loop_en),
        .i_frame_step    (r_frame_step),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_eased_time    (o_eased_time),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_segment_index (o_segment_index),
        .o_segment_done  (o_segment_done),
        .o_running       (o_running)
    );

endmodule
